// ----- rtl/rbsi_pkg.sv -----
// shared types and constants for the ray versus box slab test
package rbsi_pkg;

    localparam int CoordWidth = 32;
    localparam int FracBits   = 16;
    // numerator magnitude is at most 2^CoordWidth, one bit more than a coordinate
    localparam int NumWidth   = CoordWidth + 1;
    // quotient bits: integer part plus fraction bits
    localparam int QuoWidth   = NumWidth + FracBits;
    // divider stages, one quotient bit each
    localparam int DivSteps   = QuoWidth;

    localparam logic signed [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
    localparam logic signed [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

    typedef struct packed {
        logic signed [CoordWidth-1:0] origin_x;
        logic signed [CoordWidth-1:0] origin_y;
        logic signed [CoordWidth-1:0] origin_z;
        logic signed [CoordWidth-1:0] direction_x;
        logic signed [CoordWidth-1:0] direction_y;
        logic signed [CoordWidth-1:0] direction_z;
        logic signed [CoordWidth-1:0] box_min_x;
        logic signed [CoordWidth-1:0] box_min_y;
        logic signed [CoordWidth-1:0] box_min_z;
        logic signed [CoordWidth-1:0] box_max_x;
        logic signed [CoordWidth-1:0] box_max_y;
        logic signed [CoordWidth-1:0] box_max_z;
    } t_ray_box;

    typedef struct packed {
        logic                         hit;
        logic signed [CoordWidth-1:0] entry_distance;
    } t_result;

    // per-axis status carried beside the divider pipeline
    typedef struct packed {
        logic zero_dir;    // direction component is zero
        logic outside;     // origin outside this axis' slab
    } t_axis_flags;

    // item status carried beside the divider pipeline
    typedef struct packed {
        logic        in_box;
        t_axis_flags fx;
        t_axis_flags fy;
        t_axis_flags fz;
    } t_item_flags;

endpackage

// ----- rtl/rbsi_div_pipe.sv -----
// pipelined restoring divider: fixed-point quotient, truncated, saturated
module rbsi_div_pipe (
    input  logic                                   i_clk,
    input  logic signed [rbsi_pkg::NumWidth-1:0]   i_num,
    input  logic signed [rbsi_pkg::CoordWidth-1:0] i_den,
    output logic signed [rbsi_pkg::CoordWidth-1:0] o_quo
);

    localparam int NW = rbsi_pkg::NumWidth;
    localparam int QW = rbsi_pkg::QuoWidth;
    localparam int CW = rbsi_pkg::CoordWidth;
    localparam int ST = rbsi_pkg::DivSteps;

    // dividend shifted by the fraction bits; remainder never exceeds the divisor width
    logic [QW-1:0] r_dvd [ST+1];
    logic [CW:0]   r_rem [ST+1];
    logic [CW-1:0] r_dsr [ST+1];
    logic          r_neg [ST+1];

    logic [NW-1:0] n_mag;
    logic [CW-1:0] n_dmag;

    // operand magnitudes
    always_comb begin
        n_mag  = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        n_dmag = i_den[CW-1] ? CW'(-i_den) : CW'(i_den);
    end

    always_ff @(posedge i_clk) begin
        r_dvd[0] <= {n_mag, {rbsi_pkg::FracBits{1'b0}}};
        r_rem[0] <= '0;
        r_dsr[0] <= n_dmag;
        r_neg[0] <= i_num[NW-1] ^ i_den[CW-1];
    end

    // one quotient bit per stage, quotient shifts into the dividend register
    for (genvar s = 0; s < ST; s++) begin : g_step
        logic [CW+1:0] n_trial;
        logic [CW+1:0] n_diff;
        always_comb begin
            n_trial = {r_rem[s], r_dvd[s][QW-1]};
            n_diff  = n_trial - {2'b00, r_dsr[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!n_diff[CW+1]) begin
                r_rem[s+1] <= n_diff[CW:0];
                r_dvd[s+1] <= {r_dvd[s][QW-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_trial[CW:0];
                r_dvd[s+1] <= {r_dvd[s][QW-2:0], 1'b0};
            end
            r_dsr[s+1] <= r_dsr[s];
            r_neg[s+1] <= r_neg[s];
        end
    end

    logic n_sat;
    logic [QW-1:0] n_q;

    // saturate when the quotient reaches the sign bit
    always_comb begin
        n_q   = r_dvd[ST];
        n_sat = |n_q[QW-1:CW-1];
        if (n_sat) begin
            o_quo = r_neg[ST] ? rbsi_pkg::CoordMin : rbsi_pkg::CoordMax;
        end else if (r_neg[ST]) begin
            o_quo = -$signed(n_q[CW-1:0]);
        end else begin
            o_quo = $signed(n_q[CW-1:0]);
        end
    end

endmodule

// ----- rtl/rbsi_axis.sv -----
// one axis: slab differences, two dividers and ordering of entry/exit
module rbsi_axis (
    input  logic                                   i_clk,
    input  logic signed [rbsi_pkg::CoordWidth-1:0] i_origin,
    input  logic signed [rbsi_pkg::CoordWidth-1:0] i_dir,
    input  logic signed [rbsi_pkg::CoordWidth-1:0] i_lo,
    input  logic signed [rbsi_pkg::CoordWidth-1:0] i_hi,
    output logic signed [rbsi_pkg::CoordWidth-1:0] o_t_min,
    output logic signed [rbsi_pkg::CoordWidth-1:0] o_t_max
);

    localparam int NW = rbsi_pkg::NumWidth;

    logic signed [NW-1:0] n_num_lo;
    logic signed [NW-1:0] n_num_hi;
    logic signed [rbsi_pkg::CoordWidth-1:0] n_t1;
    logic signed [rbsi_pkg::CoordWidth-1:0] n_t2;

    // exact differences need one extra bit
    always_comb begin
        n_num_lo = NW'(i_lo) - NW'(i_origin);
        n_num_hi = NW'(i_hi) - NW'(i_origin);
    end

    rbsi_div_pipe u_div_lo (
        .i_clk  (i_clk),
        .i_num  (n_num_lo),
        .i_den  (i_dir),
        .o_quo  (n_t1)
    );

    rbsi_div_pipe u_div_hi (
        .i_clk  (i_clk),
        .i_num  (n_num_hi),
        .i_den  (i_dir),
        .o_quo  (n_t2)
    );

    // put entry and exit in order
    always_comb begin
        if (n_t1 > n_t2) begin
            o_t_min = n_t2;
            o_t_max = n_t1;
        end else begin
            o_t_min = n_t1;
            o_t_max = n_t2;
        end
    end

endmodule

// ----- rtl/ray_box_slab_intersect_core.sv -----
// top level: ray versus axis-aligned box slab test, fully pipelined
//
// Usage: drive i_ray_box and pulse i_start; an item transfers at each rising
// edge with start high and busy low. busy is always low: one item may
// transfer in every cycle. Each item gives exactly one result on o_result,
// marked by o_done for one cycle, in input order.
// Path: the divider input register, the bit-per-stage divider chain, the
// decision stage that registers the narrowed interval, and the output
// register that drives o_done and o_result.
// Throughput: one item per cycle.
// Reset (synchronous, active low) clears the valid bits of every stage;
// items in flight are dropped and no o_done follows until a new transfer.
// The receiver cannot stall; the pipeline never holds.
// A zero direction component gives a saturated quotient that is ignored:
// that axis then narrows nothing, or forces a miss when the origin lies
// outside its slab. An origin inside the closed box is a hit at distance 0.
module ray_box_slab_intersect_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rbsi_pkg::t_ray_box i_ray_box,
    output logic               o_done,
    output rbsi_pkg::t_result  o_result
);

    localparam int CW = rbsi_pkg::CoordWidth;
    localparam int ST = rbsi_pkg::DivSteps;

    logic n_accept;
    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    // per-axis slab status at entry
    rbsi_pkg::t_item_flags n_flags;
    always_comb begin
        n_flags.fx.outside = (i_ray_box.origin_x < i_ray_box.box_min_x)
                          || (i_ray_box.origin_x > i_ray_box.box_max_x);
        n_flags.fy.outside = (i_ray_box.origin_y < i_ray_box.box_min_y)
                          || (i_ray_box.origin_y > i_ray_box.box_max_y);
        n_flags.fz.outside = (i_ray_box.origin_z < i_ray_box.box_min_z)
                          || (i_ray_box.origin_z > i_ray_box.box_max_z);
        n_flags.fx.zero_dir = (i_ray_box.direction_x == '0);
        n_flags.fy.zero_dir = (i_ray_box.direction_y == '0);
        n_flags.fz.zero_dir = (i_ray_box.direction_z == '0);
        n_flags.in_box = !n_flags.fx.outside && !n_flags.fy.outside
                      && !n_flags.fz.outside;
    end

    // flags and valid travel beside the dividers
    rbsi_pkg::t_item_flags r_flags [ST+1];
    logic [ST:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ST-1:0], n_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags[0] <= n_flags;
        for (int s = 0; s < ST; s++) begin
            r_flags[s+1] <= r_flags[s];
        end
    end

    logic signed [CW-1:0] n_xmin, n_xmax, n_ymin, n_ymax, n_zmin, n_zmax;

    rbsi_axis u_axis_x (
        .i_clk(i_clk),
        .i_origin(i_ray_box.origin_x), .i_dir(i_ray_box.direction_x),
        .i_lo(i_ray_box.box_min_x), .i_hi(i_ray_box.box_max_x),
        .o_t_min(n_xmin), .o_t_max(n_xmax)
    );

    rbsi_axis u_axis_y (
        .i_clk(i_clk),
        .i_origin(i_ray_box.origin_y), .i_dir(i_ray_box.direction_y),
        .i_lo(i_ray_box.box_min_y), .i_hi(i_ray_box.box_max_y),
        .o_t_min(n_ymin), .o_t_max(n_ymax)
    );

    rbsi_axis u_axis_z (
        .i_clk(i_clk),
        .i_origin(i_ray_box.origin_z), .i_dir(i_ray_box.direction_z),
        .i_lo(i_ray_box.box_min_z), .i_hi(i_ray_box.box_max_z),
        .o_t_min(n_zmin), .o_t_max(n_zmax)
    );

    // narrow the interval over the axes that have a direction
    logic signed [CW-1:0] n_near, n_far;
    logic                 n_miss;
    rbsi_pkg::t_item_flags n_f;
    always_comb begin
        n_f    = r_flags[ST];
        n_near = rbsi_pkg::CoordMin;
        n_far  = rbsi_pkg::CoordMax;
        n_miss = (n_f.fx.zero_dir && n_f.fx.outside)
              || (n_f.fy.zero_dir && n_f.fy.outside)
              || (n_f.fz.zero_dir && n_f.fz.outside);
        if (!n_f.fx.zero_dir) begin
            if (n_xmin > n_near) n_near = n_xmin;
            if (n_xmax < n_far)  n_far  = n_xmax;
        end
        if (!n_f.fy.zero_dir) begin
            if (n_ymin > n_near) n_near = n_ymin;
            if (n_ymax < n_far)  n_far  = n_ymax;
        end
        if (!n_f.fz.zero_dir) begin
            if (n_zmin > n_near) n_near = n_zmin;
            if (n_zmax < n_far)  n_far  = n_zmax;
        end
    end

    // decision stage
    logic signed [CW-1:0] r_near, r_far;
    logic                 r_miss, r_inside, r_dvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= 1'b0;
        end else begin
            r_dvld <= r_vld[ST];
        end
    end

    always_ff @(posedge i_clk) begin
        r_near   <= n_near;
        r_far    <= n_far;
        r_miss   <= n_miss;
        r_inside <= n_f.in_box;
    end

    // output register
    logic              r_done;
    rbsi_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_inside) begin
            r_result.hit            <= 1'b1;
            r_result.entry_distance <= '0;
        end else if (!r_miss && !r_near[CW-1] && (r_near < r_far)) begin
            r_result.hit            <= 1'b1;
            r_result.entry_distance <= r_near;
        end else begin
            r_result.hit            <= 1'b0;
            r_result.entry_distance <= '0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- tb/sv/ray_box_slab_intersect_core_checker.sv -----
// checker for the ray versus box slab test: predicts and compares results
module ray_box_slab_intersect_core_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  rbsi_pkg::t_ray_box i_ray_box,
    input  logic               i_done,
    input  rbsi_pkg::t_result  i_result,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SignBit = longint'(1) << (rbsi_pkg::CoordWidth - 1);
    localparam longint MaxVal  = SignBit - 1;
    localparam longint MinVal  = -SignBit;

    rbsi_pkg::t_result expected_hits[$];

    // fixed point quotient, truncated toward zero, saturating
    function automatic longint slab_quotient(longint num, longint den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic neg;
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        q   = (n << rbsi_pkg::FracBits) / d;
        if (q >= SignBit) return neg ? MinVal : MaxVal;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic rbsi_pkg::t_result predict_hit(rbsi_pkg::t_ray_box rb);
        longint o[3], d[3], lo[3], hi[3];
        longint t1, t2, t_near, t_far, s;
        logic in_box, miss;
        rbsi_pkg::t_result res;
        o  = '{rb.origin_x, rb.origin_y, rb.origin_z};
        d  = '{rb.direction_x, rb.direction_y, rb.direction_z};
        lo = '{rb.box_min_x, rb.box_min_y, rb.box_min_z};
        hi = '{rb.box_max_x, rb.box_max_y, rb.box_max_z};
        t_near = MinVal;
        t_far  = MaxVal;
        in_box = 1'b1;
        miss   = 1'b0;
        res    = '0;
        for (int a = 0; a < 3; a++) begin
            if (o[a] < lo[a] || o[a] > hi[a]) in_box = 1'b0;
        end
        if (in_box) begin
            res.hit = 1'b1;
            return res;
        end
        // narrow the interval axis by axis
        for (int a = 0; a < 3; a++) begin
            if (d[a] == 0) begin
                if (o[a] < lo[a] || o[a] > hi[a]) miss = 1'b1;
            end else begin
                t1 = slab_quotient(lo[a] - o[a], d[a]);
                t2 = slab_quotient(hi[a] - o[a], d[a]);
                if (t1 > t2) begin
                    s  = t1;
                    t1 = t2;
                    t2 = s;
                end
                if (t1 > t_near) t_near = t1;
                if (t2 < t_far) t_far = t2;
            end
        end
        if (!miss && t_near >= 0 && t_near < t_far) begin
            res.hit            = 1'b1;
            res.entry_distance = t_near[rbsi_pkg::CoordWidth-1:0];
        end
        return res;
    endfunction

    // queue expectations on input transfers, compare on result strobes
    always @(posedge i_clk) begin
        rbsi_pkg::t_result exp_res;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            expected_hits.delete();
            o_fail_count <= 0;
        end else begin
            if (i_done) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result: hit %0b entry_distance %0d",
                        i_result.hit, i_result.entry_distance);
                    errs++;
                end else begin
                    exp_res = expected_hits.pop_front();
                    if (i_result.hit !== exp_res.hit) begin
                        $error("hit: expected %0b actual %0b", exp_res.hit, i_result.hit);
                        errs++;
                    end
                    if (i_result.entry_distance !== exp_res.entry_distance) begin
                        $error("entry_distance: expected %0d actual %0d",
                            exp_res.entry_distance, i_result.entry_distance);
                        errs++;
                    end
                end
            end
            if (i_start && !i_busy) expected_hits.push_back(predict_hit(i_ray_box));
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

    assign o_pending = expected_hits.size();
endmodule

// ----- tb/sv/ray_box_slab_intersect_core_tb.sv -----
// testbench top for the ray versus box slab test: stimulus and verdict
module ray_box_slab_intersect_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomRays = 1380;
    localparam int StallLimit = 2000;
    localparam int Latency    = rbsi_pkg::DivSteps + 3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    rbsi_pkg::t_ray_box ray_box;
    logic               done;
    rbsi_pkg::t_result  result;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;

    ray_box_slab_intersect_core i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .start     (start),
        .busy      (busy),
        .i_ray_box (ray_box),
        .o_done    (done),
        .o_result  (result)
    );

    ray_box_slab_intersect_core_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_ray_box    (ray_box),
        .i_done       (done),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: cycles without a transfer or a result
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [rbsi_pkg::CoordWidth-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return rbsi_pkg::CoordMax;
            2: return rbsi_pkg::CoordMin;
            3: return $signed(32'($urandom_range(0, 8))) - 4;
            default: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
        endcase
    endfunction

    // box bounds mostly ordered, sometimes all fields random; direction may be zero
    function automatic rbsi_pkg::t_ray_box rand_ray();
        rbsi_pkg::t_ray_box rb;
        logic signed [rbsi_pkg::CoordWidth-1:0] a, b;
        rb = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) < 2) return rb;
        for (int k = 0; k < 3; k++) begin
            a = rand_coord();
            b = rand_coord();
            if (a > b && $urandom_range(0, 9) != 0) {a, b} = {b, a};
            case (k)
                0: {rb.box_min_x, rb.box_max_x} = {a, b};
                1: {rb.box_min_y, rb.box_max_y} = {a, b};
                default: {rb.box_min_z, rb.box_max_z} = {a, b};
            endcase
        end
        rb.origin_x = rand_coord();
        rb.origin_y = rand_coord();
        rb.origin_z = rand_coord();
        rb.direction_x = ($urandom_range(0, 7) == 0) ? '0 : rand_coord();
        rb.direction_y = ($urandom_range(0, 7) == 0) ? '0 : rand_coord();
        rb.direction_z = ($urandom_range(0, 7) == 0) ? '0 : rand_coord();
        return rb;
    endfunction

    // one transfer, then an optional gap
    task automatic send_ray(rbsi_pkg::t_ray_box rb);
        int gap;
        start   <= 1'b1;
        ray_box <= rb;
        @(posedge clk);
        while (busy) @(posedge clk);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic rbsi_pkg::t_ray_box unit_ray(
            logic signed [rbsi_pkg::CoordWidth-1:0] ox,
            logic signed [rbsi_pkg::CoordWidth-1:0] dx);
        rbsi_pkg::t_ray_box rb;
        rb = '0;
        rb.origin_x  = ox;
        rb.direction_x = dx;
        rb.box_min_x = 32'sh0001_0000;
        rb.box_max_x = 32'sh0002_0000;
        rb.box_min_y = -32'sh0001_0000;
        rb.box_max_y = 32'sh0001_0000;
        rb.box_min_z = -32'sh0001_0000;
        rb.box_max_z = 32'sh0001_0000;
        return rb;
    endfunction

    initial begin
        rbsi_pkg::t_ray_box rb;
        rst_n       = 1'b0;
        start       = 1'b0;
        ray_box     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: inside, hit in front, behind, zero direction, overflow
        send_ray(unit_ray(32'sh0001_8000, 32'sh0001_0000));
        send_ray(unit_ray('0, 32'sh0001_0000));
        send_ray(unit_ray('0, -32'sh0001_0000));
        send_ray(unit_ray('0, 32'sh0000_0001));
        send_ray(unit_ray('0, '0));
        send_ray(unit_ray(32'sh0003_0000, -32'sh0000_8000));
        send_ray(unit_ray(32'sh0003_0000, 32'sh0001_0000));
        send_ray(unit_ray(rbsi_pkg::CoordMin, rbsi_pkg::CoordMax));
        send_ray(unit_ray(rbsi_pkg::CoordMax, rbsi_pkg::CoordMin));
        send_ray(unit_ray(rbsi_pkg::CoordMin, 32'sh0000_0001));
        send_ray(unit_ray(32'sh0001_0000, 32'sh0001_0000));
        rb = unit_ray('0, 32'sh0001_0000);
        rb.origin_y = 32'sh0005_0000;
        send_ray(rb);
        rb.box_min_z = 32'sh0001_0000;
        rb.box_max_z = -32'sh0001_0000;
        rb.origin_y = '0;
        send_ray(rb);
        rb = {12{rbsi_pkg::CoordMax}};
        send_ray(rb);
        rb = {12{rbsi_pkg::CoordMin}};
        send_ray(rb);
        rb = '0;
        send_ray(rb);
        rb = '1;
        send_ray(rb);

        // random
        for (int n = 0; n < RandomRays; n++) send_ray(rand_ray());
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (Latency + 5) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
